FILE: hw/rtl/icrf_pkg.sv
// Package for the indexed control register file.
// Transfer types, function codes, the special-entry map and its power-on image.
// No dependencies.
package icrf_pkg;

   localparam int ENTRIES    = 256;
   localparam int IDX_W      = 8;
   localparam int SPEC_COUNT = 20;
   localparam int SLOT_W     = 5;

   localparam logic [2:0] FUNC_SELECT     = 3'd0;
   localparam logic [2:0] FUNC_READ       = 3'd1;
   localparam logic [2:0] FUNC_WRITE      = 3'd2;
   localparam logic [2:0] FUNC_SOFT_RESET = 3'd3;
   localparam logic [2:0] FUNC_NMI_LATCH  = 3'd4;

   localparam logic [IDX_W-1:0] SEL_RESET    = 8'h24;
   localparam logic [IDX_W-1:0] REG_CFG_MODE = 8'h03;

   // slots of the entries held in flops
   localparam logic [SLOT_W-1:0] SLOT_X06 = 5'd3;
   localparam logic [SLOT_W-1:0] SLOT_X7F = 5'd7;
   localparam logic [SLOT_W-1:0] SLOT_X80 = 5'd8;
   localparam logic [SLOT_W-1:0] SLOT_X82 = 5'd9;
   localparam logic [SLOT_W-1:0] SLOT_X83 = 5'd10;
   localparam logic [SLOT_W-1:0] SLOT_X84 = 5'd11;
   localparam logic [SLOT_W-1:0] SLOT_X85 = 5'd12;
   localparam logic [SLOT_W-1:0] SLOT_X86 = 5'd13;
   localparam logic [SLOT_W-1:0] SLOT_X87 = 5'd14;
   localparam logic [SLOT_W-1:0] SLOT_X88 = 5'd15;
   localparam logic [SLOT_W-1:0] SLOT_X89 = 5'd16;
   localparam logic [SLOT_W-1:0] SLOT_X8C = 5'd17;
   localparam logic [SLOT_W-1:0] SLOT_XC2 = 5'd18;
   localparam logic [SLOT_W-1:0] SLOT_XC3 = 5'd19;

   localparam logic [7:0] SPEC_ADDR [SPEC_COUNT] = '{
      8'h00, 8'h01, 8'h05, 8'h06, 8'h0B, 8'h0E, 8'h10, 8'h7F, 8'h80, 8'h82,
      8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8C, 8'hC2, 8'hC3
   };

   localparam logic [7:0] SPEC_POR [SPEC_COUNT] = '{
      8'h08, 8'h32, 8'h41, 8'hA0, 8'h01, 8'h03, 8'h04, 8'hFF, 8'h00, 8'hFF,
      8'hFF, 8'hFF, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h8F, 8'h00, 8'h00, 8'h00
   };

   typedef struct packed {
      logic [2:0]       func;
      logic [IDX_W-1:0] reg_index;
      logic [7:0]       wdata;
      logic [15:0]      nmi_pc;
   } req_type;

   typedef struct packed {
      logic [7:0]       read_data;
      logic [IDX_W-1:0] sel_index;
      logic             cfg_mode;
   } rsp_type;

   typedef struct packed {
      logic op;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } lookup_type;

   function automatic lookup_type spec_lookup(input logic [IDX_W-1:0] idx);
      lookup_type r;
      r = '0;
      for (int i = 0; i < SPEC_COUNT; i++) begin
         if (SPEC_ADDR[i] == idx) begin
            r.hit  = 1'b1;
            r.slot = SLOT_W'(i);
         end
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/indexed_control_register_file.sv
// Indexed control register file: 256 bytes behind a select/data pair.
// The result is formed in the execute state and valid in the respond state; a new
// transfer is taken only once the result is handed over, by the controller's
// operate / form-result / hand-over sequence around the registered memory read.
// Reset loads the power-on image at once: per-entry valid bits clear, no sweep.
module indexed_control_register_file (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  icrf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output icrf_pkg::rsp_type rsp_data
);

   icrf_pkg::cmd_type cmd;

   icrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   icrf_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req_data),
      .rsp   (rsp_data)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result is pending");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##2 rsp_valid)
      else $error("result not presented two cycles after transfer");

   a_soft_reset_sel: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.func == icrf_pkg::FUNC_SOFT_RESET)
      |-> ##2 (rsp_data.sel_index == icrf_pkg::SEL_RESET))
      else $error("soft reset did not restore the selected index");

endmodule

FILE: hw/rtl/icrf_ctrl.sv
// Controller of the indexed control register file.
// Sequences one transfer at a time: operate, form result, hand over. Uses icrf_pkg.
module icrf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output icrf_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_RESP} state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff     <= S_EXEC;
                  req_ready_ff <= 1'b0;
               end
            end
            S_EXEC: begin
               state_ff     <= S_RESP;
               rsp_valid_ff <= 1'b1;
            end
            S_RESP: begin
               if (rsp_ready) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               req_ready_ff <= 1'b1;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_ready    = req_ready_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign cmd.op       = req_ready_ff && req_valid;
   assign cmd.load_rsp = (state_ff == S_EXEC);

endmodule

FILE: hw/rtl/icrf_datapath.sv
// Datapath of the indexed control register file.
// Byte memory with per-entry valid bits, flop-held special entries, select and mode latches.
// Uses icrf_pkg.
module icrf_datapath (
   input  logic              clock,
   input  logic              reset,
   input  icrf_pkg::cmd_type cmd,
   input  icrf_pkg::req_type req,
   output icrf_pkg::rsp_type rsp
);

   logic [7:0] mem [icrf_pkg::ENTRIES];
   logic [7:0] mem_rd_ff;

   logic [icrf_pkg::ENTRIES-1:0] valid_ff, valid_in;
   logic [7:0] spec_ff [icrf_pkg::SPEC_COUNT];
   logic [7:0] spec_in [icrf_pkg::SPEC_COUNT];
   logic [7:0] spec_soft [icrf_pkg::SPEC_COUNT];
   logic [icrf_pkg::IDX_W-1:0] sel_ff, sel_in;
   logic       cfg_ff, cfg_in;
   logic [2:0] func_ff;
   icrf_pkg::rsp_type    rsp_ff;
   icrf_pkg::lookup_type lk;
   logic       mem_we;
   logic [7:0] rd_byte;

   assign lk = icrf_pkg::spec_lookup(sel_ff);

   always_comb begin
      spec_soft = icrf_pkg::SPEC_POR;
      spec_soft[icrf_pkg::SLOT_X06] = spec_ff[icrf_pkg::SLOT_X06] | 8'hA0;
      spec_soft[icrf_pkg::SLOT_X7F] = spec_ff[icrf_pkg::SLOT_X7F];
      spec_soft[icrf_pkg::SLOT_X80] = {2{spec_ff[icrf_pkg::SLOT_X80][3:0]}};
      spec_soft[icrf_pkg::SLOT_X8C] = {2{spec_ff[icrf_pkg::SLOT_X8C][3:0]}};
      if (!spec_ff[icrf_pkg::SLOT_X85][7]) begin
         spec_soft[icrf_pkg::SLOT_X82] = spec_ff[icrf_pkg::SLOT_X82];
         spec_soft[icrf_pkg::SLOT_X83] = spec_ff[icrf_pkg::SLOT_X83];
         spec_soft[icrf_pkg::SLOT_X84] = spec_ff[icrf_pkg::SLOT_X84];
         spec_soft[icrf_pkg::SLOT_X85] = spec_ff[icrf_pkg::SLOT_X85] & 8'h8F;
      end
      if (spec_ff[icrf_pkg::SLOT_X89][7]) begin
         spec_soft[icrf_pkg::SLOT_X86] = spec_ff[icrf_pkg::SLOT_X86];
         spec_soft[icrf_pkg::SLOT_X87] = spec_ff[icrf_pkg::SLOT_X87];
         spec_soft[icrf_pkg::SLOT_X88] = spec_ff[icrf_pkg::SLOT_X88];
         spec_soft[icrf_pkg::SLOT_X89] = spec_ff[icrf_pkg::SLOT_X89] & 8'h8F;
      end else begin
         spec_soft[icrf_pkg::SLOT_X89] = 8'h0F;
      end
   end

   always_comb begin
      spec_in  = spec_ff;
      valid_in = valid_ff;
      sel_in   = sel_ff;
      cfg_in   = cfg_ff;
      mem_we   = 1'b0;
      if (cmd.op) begin
         case (req.func)
            icrf_pkg::FUNC_SELECT: begin
               sel_in = req.reg_index;
            end
            icrf_pkg::FUNC_WRITE: begin
               if (lk.hit) begin
                  spec_in[lk.slot] = req.wdata;
               end else begin
                  mem_we           = 1'b1;
                  valid_in[sel_ff] = 1'b1;
               end
               if (sel_ff == icrf_pkg::REG_CFG_MODE) begin
                  if (req.wdata[2:0] == 3'b111) begin
                     cfg_in = 1'b1;
                  end else if (req.wdata[2:0] != 3'b000) begin
                     cfg_in = 1'b0;
                  end
               end
            end
            icrf_pkg::FUNC_SOFT_RESET: begin
               spec_in  = spec_soft;
               valid_in = '0;
               sel_in   = icrf_pkg::SEL_RESET;
            end
            icrf_pkg::FUNC_NMI_LATCH: begin
               spec_in[icrf_pkg::SLOT_XC2] = req.nmi_pc[7:0];
               spec_in[icrf_pkg::SLOT_XC3] = req.nmi_pc[15:8];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spec_ff  <= icrf_pkg::SPEC_POR;
         valid_ff <= '0;
         sel_ff   <= icrf_pkg::SEL_RESET;
         cfg_ff   <= 1'b1;
      end else begin
         spec_ff  <= spec_in;
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
         cfg_ff   <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[sel_ff] <= req.wdata;
      end
      if (cmd.op) begin
         mem_rd_ff <= mem[sel_ff];
         func_ff   <= req.func;
      end
   end

   // entries held in flops are untouched by a read, so they are taken here directly
   always_comb begin
      if (func_ff != icrf_pkg::FUNC_READ) begin
         rd_byte = 8'h00;
      end else if (lk.hit) begin
         rd_byte = spec_ff[lk.slot];
      end else if (valid_ff[sel_ff]) begin
         rd_byte = mem_rd_ff;
      end else begin
         rd_byte = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.read_data <= rd_byte;
         rsp_ff.sel_index <= sel_ff;
         rsp_ff.cfg_mode  <= cfg_ff;
      end
   end

   assign rsp = rsp_ff;

endmodule

FILE: verif/indexed_control_register_file_test.sv
// Self-checking testbench for indexed_control_register_file.
// Drives request transfers, predicts every response with its own model of the
// register file and compares field by field. Depends on icrf_pkg and the RTL only.
module indexed_control_register_file_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 4000;

   localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
   localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

   localparam logic [7:0] ENT_X00  = 8'h00;
   localparam logic [7:0] ENT_X01  = 8'h01;
   localparam logic [7:0] ENT_X05  = 8'h05;
   localparam logic [7:0] ENT_X06  = 8'h06;
   localparam logic [7:0] ENT_X0B  = 8'h0B;
   localparam logic [7:0] ENT_X0E  = 8'h0E;
   localparam logic [7:0] ENT_X10  = 8'h10;
   localparam logic [7:0] ENT_X7F  = 8'h7F;
   localparam logic [7:0] ENT_X80  = 8'h80;
   localparam logic [7:0] ENT_X82  = 8'h82;
   localparam logic [7:0] ENT_X83  = 8'h83;
   localparam logic [7:0] ENT_X84  = 8'h84;
   localparam logic [7:0] ENT_X85  = 8'h85;
   localparam logic [7:0] ENT_X86  = 8'h86;
   localparam logic [7:0] ENT_X87  = 8'h87;
   localparam logic [7:0] ENT_X88  = 8'h88;
   localparam logic [7:0] ENT_X89  = 8'h89;
   localparam logic [7:0] ENT_X8C  = 8'h8C;
   localparam logic [7:0] ENT_XC2  = 8'hC2;
   localparam logic [7:0] ENT_XC3  = 8'hC3;
   localparam logic [7:0] ENT_LAST = 8'hFF;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   icrf_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   icrf_pkg::rsp_type rsp_data;

   bit                idling   = 1'b1;
   bit                hold_due = 1'b0;
   int                failures = 0;
   int                quiet_cycles = 0;
   icrf_pkg::rsp_type awaited[$];
   icrf_pkg::rsp_type due;

   bit [7:0]   model_mem [256];
   bit [7:0]   model_sel;
   bit         model_cfg;

   indexed_control_register_file u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void model_soft_reset();
      bit [7:0] prev [256];
      prev = model_mem;
      foreach (model_mem[i]) model_mem[i] = '0;
      model_mem[ENT_X7F] = prev[ENT_X7F];
      model_mem[ENT_X80] = {2{prev[ENT_X80][3:0]}};
      model_mem[ENT_X8C] = {2{prev[ENT_X8C][3:0]}};
      model_mem[ENT_X06] = prev[ENT_X06] | 8'hA0;
      model_mem[ENT_X00] = 8'h08;
      model_mem[ENT_X01] = 8'h32;
      model_mem[ENT_X05] = 8'h41;
      model_mem[ENT_X0B] = 8'h01;
      model_mem[ENT_X0E] = 8'h03;
      model_mem[ENT_X10] = 8'h04;
      if (prev[ENT_X85][7]) begin
         model_mem[ENT_X82] = 8'hFF;
         model_mem[ENT_X83] = 8'hFF;
         model_mem[ENT_X84] = 8'hFF;
         model_mem[ENT_X85] = 8'h8F;
      end else begin
         model_mem[ENT_X82] = prev[ENT_X82];
         model_mem[ENT_X83] = prev[ENT_X83];
         model_mem[ENT_X84] = prev[ENT_X84];
         model_mem[ENT_X85] = prev[ENT_X85] & 8'h8F;
      end
      if (!prev[ENT_X89][7]) begin
         model_mem[ENT_X86] = 8'hFF;
         model_mem[ENT_X87] = 8'hFF;
         model_mem[ENT_X88] = 8'hFF;
         model_mem[ENT_X89] = 8'h0F;
      end else begin
         model_mem[ENT_X86] = prev[ENT_X86];
         model_mem[ENT_X87] = prev[ENT_X87];
         model_mem[ENT_X88] = prev[ENT_X88];
         model_mem[ENT_X89] = prev[ENT_X89] & 8'h8F;
      end
      model_sel = icrf_pkg::SEL_RESET;
   endfunction

   function automatic void model_power_on();
      foreach (model_mem[i]) model_mem[i] = '0;
      model_mem[ENT_X82] = 8'hFF;
      model_mem[ENT_X83] = 8'hFF;
      model_mem[ENT_X84] = 8'hFF;
      model_mem[ENT_X85] = 8'h8F;
      model_mem[ENT_X86] = 8'hFF;
      model_mem[ENT_X87] = 8'hFF;
      model_mem[ENT_X88] = 8'hFF;
      model_mem[ENT_X89] = 8'h8F;
      model_mem[ENT_X7F] = 8'hFF;
      model_sel = icrf_pkg::SEL_RESET;
      model_cfg = 1'b1;
      model_soft_reset();
   endfunction

   // applies one function to the model and returns the response it yields
   function automatic icrf_pkg::rsp_type file_step(input icrf_pkg::req_type item);
      icrf_pkg::rsp_type res;
      res = '0;
      case (item.func)
         icrf_pkg::FUNC_SELECT: model_sel = item.reg_index;
         icrf_pkg::FUNC_READ: res.read_data = model_mem[model_sel];
         icrf_pkg::FUNC_WRITE: begin
            model_mem[model_sel] = item.wdata;
            if (model_sel == icrf_pkg::REG_CFG_MODE) begin
               if (item.wdata[2:0] == 3'b111)
                  model_cfg = 1'b1;
               else if (item.wdata[2:0] != 3'b000)
                  model_cfg = 1'b0;
            end
         end
         icrf_pkg::FUNC_SOFT_RESET: model_soft_reset();
         icrf_pkg::FUNC_NMI_LATCH: begin
            model_mem[ENT_XC2] = item.nmi_pc[7:0];
            model_mem[ENT_XC3] = item.nmi_pc[15:8];
         end
         default: ;
      endcase
      res.sel_index = model_sel;
      res.cfg_mode  = model_cfg;
      return res;
   endfunction

   initial model_power_on();

   function automatic icrf_pkg::req_type make_item(input logic [2:0] f);
      icrf_pkg::req_type r;
      r.func      = f;
      r.reg_index = 8'($urandom_range(0, 255));
      r.wdata     = 8'($urandom_range(0, 255));
      r.nmi_pc    = 16'($urandom_range(0, 65535));
      return r;
   endfunction

   function automatic logic [7:0] pick_index();
      int c;
      c = $urandom_range(0, 99);
      if (c < 40)
         return icrf_pkg::SPEC_ADDR[$urandom_range(0, icrf_pkg::SPEC_COUNT - 1)];
      if (c < 50)
         return icrf_pkg::REG_CFG_MODE;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_transfer(input icrf_pkg::req_type item);
      int gap;
      if (idling && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      awaited.push_back(file_step(item));
   endtask

   task automatic await_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited.size() != 0);
   endtask

   task automatic do_select(input logic [7:0] idx);
      icrf_pkg::req_type r;
      r = make_item(icrf_pkg::FUNC_SELECT);
      r.reg_index = idx;
      send_transfer(r);
   endtask

   task automatic do_write(input logic [7:0] value);
      icrf_pkg::req_type r;
      r = make_item(icrf_pkg::FUNC_WRITE);
      r.wdata = value;
      send_transfer(r);
   endtask

   task automatic do_nmi(input logic [15:0] pc);
      icrf_pkg::req_type r;
      r = make_item(icrf_pkg::FUNC_NMI_LATCH);
      r.nmi_pc = pc;
      send_transfer(r);
   endtask

   task automatic do_func(input logic [2:0] f);
      send_transfer(make_item(f));
   endtask

   // select/access runs with random content, spiced with resets, latches and noise
   task automatic random_sequences(input int n_items);
      int sent;
      int c;
      int k;
      sent = 0;
      while (sent < n_items) begin
         c = $urandom_range(0, 99);
         if (c < 72) begin
            do_select(pick_index());
            k = $urandom_range(1, 3);
            repeat (k) do_func($urandom_range(0, 1) ? icrf_pkg::FUNC_READ
                                                    : icrf_pkg::FUNC_WRITE);
            sent += k + 1;
         end else if (c < 77) begin
            do_func(icrf_pkg::FUNC_SOFT_RESET);
            sent++;
         end else if (c < 85) begin
            do_func(icrf_pkg::FUNC_NMI_LATCH);
            sent++;
         end else if (c < 88) begin
            do_func(3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI)));
            sent++;
         end else begin
            send_transfer(make_item(3'($urandom_range(0, 7))));
            sent++;
         end
      end
   endtask

   task automatic test_extremes();
      do_select(ENT_X00);
      do_func(icrf_pkg::FUNC_READ);
      do_select(ENT_LAST);
      do_write(8'hFF);
      do_func(icrf_pkg::FUNC_READ);
      do_write(8'h00);
      do_func(icrf_pkg::FUNC_READ);
      await_results();
   endtask

   task automatic test_config_mode();
      do_select(icrf_pkg::REG_CFG_MODE);
      do_write(8'h07);
      do_write(8'hF8);
      do_write(8'h05);
      do_write(8'h00);
      do_write(8'hFF);
      do_func(icrf_pkg::FUNC_SOFT_RESET);
      await_results();
   endtask

   task automatic test_nmi_and_spare_funcs();
      icrf_pkg::req_type r;
      do_nmi(16'hFFFF);
      do_select(ENT_XC3);
      do_func(icrf_pkg::FUNC_READ);
      do_nmi(16'h0000);
      do_func(icrf_pkg::FUNC_READ);
      for (int f = FUNC_UNUSED_LO; f <= FUNC_UNUSED_HI; f++) begin
         r = '1;
         r.func = 3'(f);
         send_transfer(r);
      end
      await_results();
   endtask

   task automatic test_soft_reset_branches();
      do_select(ENT_X85);
      do_write(8'h70);
      do_select(ENT_X89);
      do_write(8'hF5);
      do_select(ENT_X82);
      do_write(8'h12);
      do_func(icrf_pkg::FUNC_SOFT_RESET);
      do_select(ENT_X82);
      do_func(icrf_pkg::FUNC_READ);
      await_results();
   endtask

   task automatic test_backpressure();
      hold_due = 1'b1;
      random_sequences(40);
      await_results();
   endtask

   task automatic test_random_traffic();
      random_sequences(1300);
      await_results();
   endtask

   task automatic test_steady_stream();
      idling = 1'b0;
      random_sequences(280);
      await_results();
   endtask

   initial begin : result_sink
      int stall;
      forever begin
         @(posedge clock);
         if (hold_due) begin
            hold_due = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else if (idling && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 18);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
         end else
            rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited.size() == 0) begin
            $error("response transfer with no request outstanding");
            failures++;
         end else begin
            due = awaited.pop_front();
            if (rsp_data.read_data !== due.read_data) begin
               $error("read_data expected %02h got %02h", due.read_data, rsp_data.read_data);
               failures++;
            end
            if (rsp_data.sel_index !== due.sel_index) begin
               $error("sel_index expected %02h got %02h", due.sel_index, rsp_data.sel_index);
               failures++;
            end
            if (rsp_data.cfg_mode !== due.cfg_mode) begin
               $error("cfg_mode expected %0b got %0b", due.cfg_mode, rsp_data.cfg_mode);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("indexed_control_register_file_test NOT OK");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_config_mode();
      test_nmi_and_spare_funcs();
      test_soft_reset_branches();
      test_backpressure();
      test_random_traffic();
      test_steady_stream();
      repeat (10) @(posedge clock);
      if (failures == 0)
         $display("indexed_control_register_file_test OK");
      else
         $display("indexed_control_register_file_test NOT OK");
      $finish;
   end

endmodule
